/* sv/bba_pkg.sv */
package bba_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W  = 5;
	localparam int unsigned IDX_W  = 12;
	localparam int unsigned CNT_W  = 13;
	localparam int unsigned ACT_W  = 2;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_FORMAT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_NOSPACE = 2'd2
	} status_t;

	localparam logic REG_FIRST_DATA_BLOCK = 1'b0;
	localparam logic REG_BLOCK_TOTAL      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_data_block;
		logic [CNT_W-1:0] block_total;
		logic             consistent;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_block;
		logic [CNT_W-1:0] free_left;
	} rsp_t;

	// Position of the lowest set bit; zero when none is set
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* sv/bitmap_block_allocator.sv */
// First-fit bitmap block allocator.
// Input channel (in_valid/in_stall) carries action and block_index; a transfer
// happens on a rising edge with in_valid high and in_stall low. Each item gives
// exactly one result on the output channel (out_valid/out_stall): status,
// granted_block and free_left. The result sits in an output register, so a
// stalled receiver holds it unchanged while the block takes the next item.
// Configuration (cfg_we/cfg_index/cfg_data) writes first_data_block (index 0)
// or block_total (index 1); write only while no item is in progress.
// The map lives in a RAM of 32-bit words, one bit per block, read and written
// by one sequencer; one item is in progress at a time.
// Steps from input transfer to result (one RAM port read per cycle):
//   allocate: reads the words between first_data_block and block_total
//     (at most 128 for 4096 blocks), one word read per cycle
//   free: read word, check and write back, respond
//   format: clear every map word, one word cleared per cycle, respond
//   rejected requests, and allocate with a zero free count: respond directly
// The next item is taken in the cycle after the result is handed to the output
// register. Reset clears the free count and the ready flag; allocate and free
// answer invalid until a format has run, which also clears the whole map.
module bitmap_block_allocator #(
	parameter int unsigned MAX_BLOCKS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bba_pkg::ACT_W-1:0]  action,
	input  logic [bba_pkg::IDX_W-1:0]  block_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [bba_pkg::IDX_W-1:0]  granted_block,
	output logic [bba_pkg::CNT_W-1:0]  free_left,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]  cfg_data
);

	localparam logic [16:0] MAX_B = 17'(MAX_BLOCKS);

	logic [bba_pkg::IDX_W-1:0] first_q;
	logic [bba_pkg::CNT_W-1:0] total_q;
	bba_pkg::cfg_t             cfg;

	logic          start;
	logic          core_idle;
	logic          rsp_valid;
	logic          rsp_take;
	bba_pkg::rsp_t rsp;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [bba_pkg::IDX_W-1:0] granted_q;
	logic [bba_pkg::CNT_W-1:0] free_left_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 12'd16;
			total_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				bba_pkg::REG_FIRST_DATA_BLOCK: first_q <= cfg_data[bba_pkg::IDX_W-1:0];
				bba_pkg::REG_BLOCK_TOTAL:      total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Usable only when the data range is non-empty and fits in the map
	assign cfg.first_data_block = first_q;
	assign cfg.block_total      = total_q;
	assign cfg.consistent       = ({1'b0, first_q} < total_q) && ({4'b0, total_q} <= MAX_B);

	// Take a new item only while the sequencer is idle
	assign in_stall = !core_idle;
	assign start    = in_valid && core_idle;

	bba_core #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.action     (action),
		.block_index(block_index),
		.idle       (core_idle),
		.rsp_valid  (rsp_valid),
		.rsp_take   (rsp_take),
		.rsp        (rsp)
	);

	// Load the output register whenever it is empty or being drained
	assign rsp_take = rsp_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: hold while stalled
	always_ff @(posedge clk) begin
		if (rsp_take) begin
			status_q    <= rsp.status;
			granted_q   <= rsp.granted_block;
			free_left_q <= rsp.free_left;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_block = granted_q;
	assign free_left     = free_left_q;

	a_out_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rsp_valid))
		else $error("result appeared without a finished item");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !core_idle)
		else $error("accepted item did not start the sequencer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(status_q)
		&& $stable(granted_q) && $stable(free_left_q)))
		else $error("stalled result changed or dropped");

endmodule

/* sv/bba_ram.sv */
module bba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/bba_core.sv */
module bba_core #(
	parameter int unsigned MAX_BLOCKS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bba_pkg::cfg_t                cfg,
	input  logic                         start,
	input  logic [bba_pkg::ACT_W-1:0]    action,
	input  logic [bba_pkg::IDX_W-1:0]    block_index,
	output logic                         idle,
	output logic                         rsp_valid,
	input  logic                         rsp_take,
	output bba_pkg::rsp_t                rsp
);

	localparam int unsigned DEPTH = (MAX_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

	bba_pkg::state_t state_q, state_d;
	logic [bba_pkg::CNT_W-1:0] free_count_q;
	logic                      ready_q;
	logic [AW:0]               scan_addr_q;
	logic [AW-1:0]             last_word_q;
	logic                      rvalid_s1;
	logic [AW-1:0]             raddr_s1;
	logic [AW-1:0]             clr_addr_q;
	logic [bba_pkg::IDX_W-1:0] idx_q;
	bba_pkg::status_t          status_q;
	logic [bba_pkg::IDX_W-1:0] granted_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [bba_pkg::WORD_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [bba_pkg::WORD_W-1:0]  ram_rdata;

	logic [bba_pkg::CNT_W-1:0]   last_pos;
	logic [AW-1:0]               first_word;
	logic [AW-1:0]               last_word;
	logic [AW-1:0]               free_word;
	logic [bba_pkg::BIT_W-1:0]   free_bit;
	logic                        free_set;
	logic                        in_range;
	logic [bba_pkg::WORD_W-1:0]  lo_mask;
	logic [bba_pkg::WORD_W-1:0]  hi_mask;
	logic [bba_pkg::WORD_W-1:0]  cand;
	logic [bba_pkg::BIT_W-1:0]   hit_bit;
	logic                        scan_in_range;
	logic                        scan_hit;
	logic                        scan_issue;

	bba_ram #(
		.WIDTH(bba_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign last_pos   = cfg.block_total - 13'd1;
	assign first_word = AW'(cfg.first_data_block >> bba_pkg::BIT_W);
	assign last_word  = AW'(last_pos >> bba_pkg::BIT_W);
	assign free_word  = AW'(idx_q >> bba_pkg::BIT_W);
	assign free_bit   = idx_q[bba_pkg::BIT_W-1:0];
	assign free_set   = ram_rdata[free_bit];
	assign in_range   = ({1'b0, block_index} >= {1'b0, cfg.first_data_block})
		&& ({1'b0, block_index} < cfg.block_total);

	// Keep only bits inside [first_data_block, block_total) on the edge words
	always_comb begin
		for (int b = 0; b < bba_pkg::WORD_W; b++) begin
			lo_mask[b] = (raddr_s1 != first_word)
				|| (bba_pkg::BIT_W'(b) >= cfg.first_data_block[bba_pkg::BIT_W-1:0]);
			hi_mask[b] = (raddr_s1 != last_word_q)
				|| (bba_pkg::BIT_W'(b) <= last_pos[bba_pkg::BIT_W-1:0]);
		end
	end

	assign cand          = ~ram_rdata & lo_mask & hi_mask;
	assign hit_bit       = bba_pkg::lowest_set(cand);
	assign scan_in_range = scan_addr_q <= {1'b0, last_word_q};
	assign scan_hit      = (state_q == bba_pkg::ST_SCAN) && rvalid_s1 && (|cand);
	assign scan_issue    = (state_q == bba_pkg::ST_SCAN) && scan_in_range && !scan_hit;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = raddr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = scan_addr_q[AW-1:0];
		case (state_q)
			bba_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bba_pkg::ST_DONE;
					case (action)
						bba_pkg::ACT_FORMAT: begin
							if (cfg.consistent) begin
								state_d = bba_pkg::ST_CLEAR;
							end
						end
						bba_pkg::ACT_ALLOC: begin
							if (cfg.consistent && ready_q && (free_count_q != '0)) begin
								state_d = bba_pkg::ST_SCAN;
							end
						end
						bba_pkg::ACT_FREE: begin
							if (cfg.consistent && ready_q && in_range) begin
								state_d = bba_pkg::ST_FREE_RD;
							end
						end
						default: state_d = bba_pkg::ST_DONE;
					endcase
				end
			end
			bba_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == LAST_WORD) begin
					state_d = bba_pkg::ST_DONE;
				end
			end
			bba_pkg::ST_FREE_RD: begin
				ram_re    = 1'b1;
				ram_raddr = free_word;
				state_d   = bba_pkg::ST_FREE_CHK;
			end
			bba_pkg::ST_FREE_CHK: begin
				if (free_set) begin
					ram_we    = 1'b1;
					ram_waddr = free_word;
					ram_wdata = ram_rdata & ~(bba_pkg::WORD_W'(1) << free_bit);
				end
				state_d = bba_pkg::ST_DONE;
			end
			bba_pkg::ST_SCAN: begin
				ram_re = scan_issue;
				if (scan_hit) begin
					ram_we    = 1'b1;
					ram_waddr = raddr_s1;
					ram_wdata = ram_rdata | (bba_pkg::WORD_W'(1) << hit_bit);
					state_d   = bba_pkg::ST_DONE;
				end else if (rvalid_s1 && !scan_in_range) begin
					state_d = bba_pkg::ST_DONE;
				end
			end
			bba_pkg::ST_DONE: begin
				if (rsp_take) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bba_pkg::ST_IDLE;
			free_count_q <= '0;
			ready_q      <= 1'b0;
			rvalid_s1    <= 1'b0;
			scan_addr_q  <= '0;
			clr_addr_q   <= '0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= scan_issue;
			if (scan_issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			case (state_q)
				bba_pkg::ST_IDLE: begin
					clr_addr_q  <= '0;
					scan_addr_q <= {1'b0, first_word};
				end
				bba_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_WORD) begin
						free_count_q <= cfg.block_total - 13'(cfg.first_data_block);
						ready_q      <= 1'b1;
					end
				end
				bba_pkg::ST_FREE_CHK: begin
					if (free_set) begin
						free_count_q <= free_count_q + 1'b1;
					end
				end
				bba_pkg::ST_SCAN: begin
					if (scan_hit) begin
						free_count_q <= free_count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result payload; no reset needed
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			raddr_s1 <= scan_addr_q[AW-1:0];
		end
		case (state_q)
			bba_pkg::ST_IDLE: begin
				if (start) begin
					idx_q       <= block_index;
					last_word_q <= last_word;
					granted_q   <= '0;
					status_q    <= bba_pkg::STATUS_INVALID;
					if ((action == bba_pkg::ACT_ALLOC) && cfg.consistent && ready_q
						&& (free_count_q == '0)) begin
						status_q <= bba_pkg::STATUS_NOSPACE;
					end
				end
			end
			bba_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_WORD) begin
					status_q <= bba_pkg::STATUS_OK;
				end
			end
			bba_pkg::ST_FREE_CHK: begin
				if (free_set) begin
					status_q <= bba_pkg::STATUS_OK;
				end
			end
			bba_pkg::ST_SCAN: begin
				if (scan_hit) begin
					status_q  <= bba_pkg::STATUS_OK;
					granted_q <= bba_pkg::IDX_W'({raddr_s1, hit_bit});
				end else if (rvalid_s1 && !scan_in_range) begin
					status_q <= bba_pkg::STATUS_NOSPACE;
				end
			end
			default: ;
		endcase
	end

	assign idle              = state_q == bba_pkg::ST_IDLE;
	assign rsp_valid         = state_q == bba_pkg::ST_DONE;
	assign rsp.status        = status_q;
	assign rsp.granted_block = granted_q;
	assign rsp.free_left     = free_count_q;

	a_scan_needs_space: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::ST_SCAN) |-> (ready_q && (free_count_q != '0)))
		else $error("scan running without free blocks or before format");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == bba_pkg::ST_SCAN))
		else $error("scan read in flight outside scan");

	a_single_bit_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ((state_q == bba_pkg::ST_SCAN) || (state_q == bba_pkg::ST_FREE_CHK)))
		|-> ($countones(ram_wdata ^ ram_rdata) == 1))
		else $error("allocate or free changed other than one bit");

endmodule
